### hdl/mcld_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mcld_pkg;

    localparam int DIV_W = 41;      // dividend width (nominal * 25-bit elapsed)
    localparam int DEN_W = 25;      // divisor width

    localparam logic [1:0] CMD_UPDATE = 2'd0;
    localparam logic [1:0] CMD_APPLY  = 2'd1;
    localparam logic [1:0] CMD_LIMP   = 2'd2;
    localparam logic [1:0] CMD_RESTART = 2'd3;

    localparam logic [2:0] CFG_NOMINAL = 3'd0;
    localparam logic [2:0] CFG_PEAK    = 3'd1;
    localparam logic [2:0] CFG_FLOOR   = 3'd2;
    localparam logic [2:0] CFG_SPAN    = 3'd3;
    localparam logic [2:0] CFG_VLOW    = 3'd4;
    localparam logic [2:0] CFG_VFULL   = 3'd5;
    localparam logic [2:0] CFG_TSTART  = 3'd6;
    localparam logic [2:0] CFG_TEND    = 3'd7;

    localparam logic [16:0] Q16_ONE      = 17'd65536;
    localparam logic [16:0] Q16_HALF     = 17'd32768;
    localparam logic [16:0] Q16_LOW_TEMP = 17'd19661;
    localparam logic [15:0] TEMP_DROP    = 16'd45875;
    localparam logic [14:0] PCT_FULL     = 15'd25600;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [15:0]        bus_voltage_mv;
        logic signed [11:0] motor_temp_dc;
        logic [15:0]        step_us;
        logic signed [23:0] demand;
        logic               limp_on;
    } in_word_t;

    typedef struct packed {
        logic [15:0]        active_limit_ma;
        logic signed [23:0] limited_demand;
        logic               was_limited;
        logic [31:0]        hit_count;
        logic               softstart_finished;
    } out_word_t;

    typedef struct packed {
        logic [3:0] cfg_idx;
        logic [23:0] cfg_data;
    } cfg_word_t;

    // datapath operation selects issued by the controller
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_LOAD  = 3'd1; // ramp add, derive factors setup
    localparam logic [2:0] OP_DRAMP = 3'd2; // start ramp division
    localparam logic [2:0] OP_DVOLT = 3'd3; // start voltage division
    localparam logic [2:0] OP_DTEMP = 3'd4; // start temperature division
    localparam logic [2:0] OP_DPCT  = 3'd5; // start percent division
    localparam logic [2:0] OP_MUL   = 3'd6; // derated limits
    localparam logic [2:0] OP_FIN   = 3'd7; // commit command, build result

    typedef struct packed {
        logic [2:0] op;
        logic       capture;  // capture divider quotient into stage register
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic [1:0] cmd;
    } dp_sts_t;

endpackage
`default_nettype wire

### hdl/mcld_divider.sv
`timescale 1ns / 1ps
`default_nettype none
module mcld_divider
    import mcld_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] dividend,
    input  wire logic [DEN_W-1:0] divisor,
    output logic                  busy,
    output logic [DIV_W-1:0]      quotient
);
    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DEN_W:0]   rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        trial = {rem_reg[DEN_W-1:0], quo_reg[DIV_W-1]};
        diff  = trial - {1'b0, den_reg};
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            den_next = divisor;
            cnt_next = CNT_W'(DIV_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = diff;
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

    a_cnt_start: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> cnt_reg == CNT_W'(DIV_W))
        else $error("divider count not loaded");
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && den_reg != '0) |-> rem_reg < {1'b0, den_reg})
        else $error("divider remainder out of range");
    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && !start) |=> cnt_reg == $past(cnt_reg) - 1'b1)
        else $error("divider count skipped");
endmodule
`default_nettype wire

### hdl/mcld_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module mcld_datapath
    import mcld_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire in_word_t  in_word,
    input  wire logic      load,
    input  wire logic      cfg_we,
    input  wire cfg_word_t cfg_word,
    input  wire dp_cmd_t   dcmd,
    output dp_sts_t        sts,
    output out_word_t      result
);
    // configuration registers
    logic [15:0] nom_reg, peak_reg, floor_reg, vlow_reg, vfull_reg;
    logic [23:0] span_reg;
    logic signed [11:0] tstart_reg, tend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nom_reg    <= 16'd10000;
            peak_reg   <= 16'd20000;
            floor_reg  <= 16'd2000;
            span_reg   <= 24'd500000;
            vlow_reg   <= 16'd20000;
            vfull_reg  <= 16'd24000;
            tstart_reg <= 12'sd600;
            tend_reg   <= 12'sd1000;
        end
        else if (cfg_we)
        begin
            case (cfg_word.cfg_idx)
                {1'b0, CFG_NOMINAL}: nom_reg    <= cfg_word.cfg_data[15:0];
                {1'b0, CFG_PEAK}:    peak_reg   <= cfg_word.cfg_data[15:0];
                {1'b0, CFG_FLOOR}:   floor_reg  <= cfg_word.cfg_data[15:0];
                {1'b0, CFG_SPAN}:    span_reg   <= cfg_word.cfg_data;
                {1'b0, CFG_VLOW}:    vlow_reg   <= cfg_word.cfg_data[15:0];
                {1'b0, CFG_VFULL}:   vfull_reg  <= cfg_word.cfg_data[15:0];
                {1'b0, CFG_TSTART}:  tstart_reg <= cfg_word.cfg_data[11:0];
                {1'b0, CFG_TEND}:    tend_reg   <= cfg_word.cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // run state
    logic [24:0] elapsed_reg;
    logic        done_reg, limp_reg;
    logic [15:0] comp_reg;
    logic [31:0] clip_reg;

    // per-item working registers
    in_word_t    w_reg;
    logic [24:0] el_new_reg;      // elapsed after the add
    logic        ramp_full_reg;   // ramp value is nominal
    logic        v_low_reg, v_full_reg, t_low_reg, t_end_reg;
    logic [16:0] v_num_reg;
    logic [16:0] v_den_reg;
    logic [12:0] t_num_reg, t_den_reg;
    logic [16:0] ramp_q_reg;
    logic [16:0] vf_reg, tf_reg;
    logic [16:0] pct_reg;
    logic [16:0] vl_reg, tl_reg;

    logic [25:0] el_sum;
    logic signed [12:0] t_diff, t_span;

    logic             dv_start;
    logic [DIV_W-1:0] dv_dividend, dv_q;
    logic [DEN_W-1:0] dv_divisor;
    logic             dv_busy;

    mcld_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_dividend),
        .divisor(dv_divisor), .busy(dv_busy), .quotient(dv_q)
    );

    assign el_sum = {1'b0, elapsed_reg} + 26'(w_reg.step_us);
    assign t_diff = 13'(w_reg.motor_temp_dc) - 13'(tstart_reg);
    assign t_span = 13'(tend_reg) - 13'(tstart_reg);

    logic [15:0] act_now;
    assign act_now = limp_reg ? floor_reg : comp_reg;

    // divider operand mux
    always_comb
    begin
        dv_start    = 1'b0;
        dv_dividend = '0;
        dv_divisor  = '0;
        case (dcmd.op)
            OP_DRAMP:
            begin
                dv_start    = 1'b1;
                dv_dividend = DIV_W'(nom_reg) * DIV_W'(el_new_reg);
                dv_divisor  = DEN_W'(span_reg);
            end
            OP_DVOLT:
            begin
                dv_start    = 1'b1;
                dv_dividend = DIV_W'({v_num_reg, 15'd0});
                dv_divisor  = DEN_W'(v_den_reg);
            end
            OP_DTEMP:
            begin
                dv_start    = 1'b1;
                dv_dividend = DIV_W'(TEMP_DROP) * DIV_W'(t_num_reg);
                dv_divisor  = DEN_W'(t_den_reg);
            end
            OP_DPCT:
            begin
                dv_start    = 1'b1;
                dv_dividend = DIV_W'(act_now) * DIV_W'(PCT_FULL);
                dv_divisor  = DEN_W'(nom_reg);
            end
            default: ;
        endcase
    end

    // quotient capture targets, set by the op that started the divider
    logic [2:0] last_div_reg;
    logic [32:0] nvf, ntf;
    logic [16:0] ramp_val, dyn0, dyn1, dyn2, clamp;
    logic [23:0] mx;
    logic signed [24:0] d_ext;
    logic signed [24:0] mx_s;
    logic clip;
    logic signed [23:0] lim;

    assign nvf = 33'(nom_reg) * 33'(vf_reg);
    assign ntf = 33'(nom_reg) * 33'(tf_reg);

    always_comb
    begin
        ramp_val = ramp_full_reg ? 17'(nom_reg) : ramp_q_reg;
        dyn0 = ramp_val;
        dyn1 = (vl_reg < dyn0) ? vl_reg : dyn0;
        dyn2 = (tl_reg < dyn1) ? tl_reg : dyn1;
        if (dyn2 > 17'(peak_reg))
            clamp = 17'(peak_reg);
        else if (dyn2 < 17'(floor_reg))
            clamp = 17'(floor_reg);
        else
            clamp = dyn2;
        mx    = (pct_reg > 17'(PCT_FULL)) ? 24'(PCT_FULL) : 24'(pct_reg);
        mx_s  = 25'(mx);
        d_ext = 25'(w_reg.demand);
        clip  = 1'b0;
        lim   = w_reg.demand;
        if (d_ext > mx_s)
        begin
            clip = 1'b1;
            lim  = mx;
        end
        else if (d_ext < -mx_s)
        begin
            clip = 1'b1;
            lim  = 24'(-mx_s);
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (load)
            w_reg <= in_word;
        if (dcmd.op == OP_LOAD)
        begin
            el_new_reg    <= el_sum[24:0];
            ramp_full_reg <= done_reg || (el_sum[24:0] >= 25'(span_reg));
            v_low_reg  <= w_reg.bus_voltage_mv <= vlow_reg;
            v_full_reg <= w_reg.bus_voltage_mv >= vfull_reg;
            v_num_reg  <= 17'(w_reg.bus_voltage_mv) - 17'(vlow_reg);
            v_den_reg  <= 17'(vfull_reg) - 17'(vlow_reg);
            t_low_reg  <= w_reg.motor_temp_dc <= tstart_reg;
            t_end_reg  <= w_reg.motor_temp_dc >= tend_reg;
            t_num_reg  <= t_diff;
            t_den_reg  <= t_span;
        end
        if (dv_start)
            last_div_reg <= dcmd.op;
        if (dcmd.capture)
        begin
            case (last_div_reg)
                OP_DRAMP: ramp_q_reg <= dv_q[16:0];
                OP_DVOLT: vf_reg <= v_low_reg ? Q16_HALF :
                                    v_full_reg ? Q16_ONE : Q16_HALF + dv_q[16:0];
                OP_DTEMP: tf_reg <= t_low_reg ? Q16_ONE :
                                    t_end_reg ? Q16_LOW_TEMP : Q16_ONE - dv_q[16:0];
                OP_DPCT:  pct_reg <= (dv_q > DIV_W'(PCT_FULL)) ? 17'(PCT_FULL) : dv_q[16:0];
                default: ;
            endcase
        end
        if (dcmd.op == OP_MUL)
        begin
            vl_reg <= nvf[32:16];
            tl_reg <= ntf[32:16];
        end
    end

    // run state and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= '0;
            done_reg    <= 1'b0;
            limp_reg    <= 1'b0;
            comp_reg    <= '0;
            clip_reg    <= '0;
            result      <= '0;
        end
        else if (dcmd.op == OP_FIN)
        begin
            result.limited_demand <= '0;
            result.was_limited    <= 1'b0;
            result.active_limit_ma <= act_now;
            result.hit_count      <= clip_reg;
            result.softstart_finished <= done_reg;
            case (w_reg.cmd)
                CMD_UPDATE:
                begin
                    if (!done_reg)
                    begin
                        elapsed_reg <= el_new_reg;
                        done_reg    <= ramp_full_reg;
                    end
                    comp_reg <= clamp[15:0];
                    result.active_limit_ma <= limp_reg ? floor_reg : clamp[15:0];
                    result.softstart_finished <= done_reg || ramp_full_reg;
                end
                CMD_APPLY:
                begin
                    if (nom_reg != '0)
                    begin
                        result.limited_demand <= lim;
                        result.was_limited    <= clip;
                        if (clip)
                        begin
                            clip_reg <= clip_reg + 1'b1;
                            result.hit_count <= clip_reg + 1'b1;
                        end
                    end
                end
                CMD_LIMP:
                begin
                    limp_reg <= w_reg.limp_on;
                    result.active_limit_ma <= w_reg.limp_on ? floor_reg : comp_reg;
                end
                default:
                begin
                    elapsed_reg <= '0;
                    done_reg    <= 1'b0;
                    limp_reg    <= 1'b0;
                    comp_reg    <= '0;
                    clip_reg    <= '0;
                    result.active_limit_ma <= '0;
                    result.hit_count <= '0;
                    result.softstart_finished <= 1'b0;
                end
            endcase
        end
    end

    assign sts.div_busy = dv_busy;
    assign sts.cmd      = w_reg.cmd;

    a_no_restart_during_div: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_start) |-> !dv_busy)
        else $error("divider started while busy");
    a_clip_count: assert property (@(posedge clk) disable iff (!rst_n)
        (dcmd.op == OP_FIN && w_reg.cmd == CMD_APPLY) |=>
        clip_reg == $past(clip_reg) || clip_reg == $past(clip_reg) + 1'b1)
        else $error("clip count jumped");
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !(dcmd.op == OP_FIN && w_reg.cmd == CMD_RESTART)) |=> done_reg)
        else $error("ramp done dropped");
endmodule
`default_nettype wire

### hdl/mcld_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module mcld_ctrl
    import mcld_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    output logic         load,
    output dp_cmd_t      dcmd,
    input  wire dp_sts_t sts
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOAD  = 4'd1;
    localparam logic [3:0] S_RAMP  = 4'd2;
    localparam logic [3:0] S_WRAMP = 4'd3;
    localparam logic [3:0] S_VOLT  = 4'd4;
    localparam logic [3:0] S_WVOLT = 4'd5;
    localparam logic [3:0] S_TEMP  = 4'd6;
    localparam logic [3:0] S_WTEMP = 4'd7;
    localparam logic [3:0] S_MUL   = 4'd8;
    localparam logic [3:0] S_PCT   = 4'd9;
    localparam logic [3:0] S_WPCT  = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    logic [3:0] state_reg, state_next;
    logic       ov_reg, ov_next;

    // a new word may enter while the previous result still waits
    assign in_ready  = (state_reg == S_IDLE);
    assign load      = in_valid && in_ready;
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next   = state_reg;
        ov_next      = ov_reg && !out_ready;
        dcmd.op      = OP_NONE;
        dcmd.capture = 1'b0;
        case (state_reg)
            S_IDLE:  if (load) state_next = S_LOAD;
            S_LOAD:
            begin
                dcmd.op = OP_LOAD;
                if (sts.cmd == CMD_UPDATE)     state_next = S_RAMP;
                else if (sts.cmd == CMD_APPLY) state_next = S_PCT;
                else                           state_next = S_FIN;
            end
            S_RAMP:  begin dcmd.op = OP_DRAMP; state_next = S_WRAMP; end
            S_WRAMP:
                if (!sts.div_busy)
                begin
                    dcmd.capture = 1'b1;
                    state_next = S_VOLT;
                end
            S_VOLT:  begin dcmd.op = OP_DVOLT; state_next = S_WVOLT; end
            S_WVOLT:
                if (!sts.div_busy)
                begin
                    dcmd.capture = 1'b1;
                    state_next = S_TEMP;
                end
            S_TEMP:  begin dcmd.op = OP_DTEMP; state_next = S_WTEMP; end
            S_WTEMP:
                if (!sts.div_busy)
                begin
                    dcmd.capture = 1'b1;
                    state_next = S_MUL;
                end
            S_MUL:   begin dcmd.op = OP_MUL; state_next = S_FIN; end
            S_PCT:   begin dcmd.op = OP_DPCT; state_next = S_WPCT; end
            S_WPCT:
                if (!sts.div_busy)
                begin
                    dcmd.capture = 1'b1;
                    state_next = S_FIN;
                end
            S_FIN:
                if (!ov_reg || out_ready)
                begin
                    dcmd.op    = OP_FIN;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
        (dcmd.op == OP_FIN) |-> (!ov_reg || out_ready))
        else $error("result overwritten");
    a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (dcmd.op == OP_FIN) |=> ov_reg)
        else $error("result not presented");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> state_reg == S_LOAD)
        else $error("accept outside idle");
endmodule
`default_nettype wire

### hdl/motor_current_limit_derater.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake             Payload
// in        in_valid/in_ready     in_word   (in_word_t)
// out       out_valid/out_ready   out_word  (out_word_t)
// cfg       cfg_valid/cfg_ready   cfg_word  (cfg_word_t, index + data)
//
// Update runs three divisions on the shared restoring divider; apply runs
// one division, limp and restart none. One word is in work at a time;
// the next is taken while the result waits in the output register. Reset
// is asynchronous, active low; a stalled result holds the last step until
// out_ready.
module motor_current_limit_derater
    import mcld_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_word_t  in_word,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_word_t      out_word,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire cfg_word_t cfg_word
);
    logic    load;
    dp_cmd_t dcmd;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    mcld_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .load(load),
        .dcmd(dcmd), .sts(sts)
    );

    mcld_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .in_word(in_word), .load(load),
        .cfg_we(cfg_valid && cfg_ready), .cfg_word(cfg_word),
        .dcmd(dcmd), .sts(sts), .result(out_word)
    );
endmodule
`default_nettype wire
